### sv/icmr_pkg.sv
package icmr_pkg;

    // result queue geometry
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_X_OFS    = 3'd0,
        REG_W_OFS    = 3'd1,
        REG_ZP_OUT   = 3'd2,
        REG_Q_MULT   = 3'd3,
        REG_Q_SHIFT  = 3'd4,
        REG_CLAMP_LO = 3'd5,
        REG_CLAMP_HI = 3'd6
    } cfg_index_t;

    // reset values of the configuration registers
    localparam logic [30:0] MULT_RESET    = 31'h4000_0000;
    localparam logic [7:0]  ACT_MIN_RESET = 8'h80;
    localparam logic [7:0]  ACT_MAX_RESET = 8'h7f;

    // requantizer sequencer states
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_SCALE,
        BK_SHIFT,
        BK_OUT
    } bk_state_t;

    // configuration as seen by the datapath
    typedef struct packed {
        logic signed [8:0] x_ofs;
        logic signed [8:0] w_ofs;
        logic signed [7:0] zp_out;
        logic [30:0]       q_mult;
        logic signed [6:0] q_shift;
        logic signed [7:0] clamp_lo;
        logic signed [7:0] clamp_hi;
    } cfg_t;

    // finished accumulator handed from the mac to the queue
    typedef struct packed {
        logic        vld;
        logic [31:0] acc;
    } acc_req_t;

    // queue status and head as seen by the requantizer
    typedef struct packed {
        logic        vld;
        logic        full;
        logic [31:0] acc;
    } q_status_t;

endpackage

### sv/int8_conv_mac_requantize.sv
// int8 convolution tap accumulator with requantization. One tap is taken per
// cycle on the slave stream for as long as the four-entry result queue has
// room; the mac folds each tap into the 32-bit accumulator register, and a
// last tap pushes the finished sum into the queue. The requantizer handles one
// result at a time (queue pop, 32x32 multiply, q0.31 rounding, rounding shift
// and clip, zero point and clamp); s_tready drops only while four results wait
// in the queue. Configuration is written through the cfg channel; the user must
// write it only while the block is idle, which the block itself does not enforce.
module int8_conv_mac_requantize (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_data,
    // taps
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // tap_value[7:0], weight_value[15:8], bias_value[47:16]
    input  logic [1:0]  s_tuser,   // tap_padded[0], first_tap[1]
    input  logic        s_tlast,   // last_tap
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // result[7:0]
);
    import icmr_pkg::*;

    cfg_t      cfg_reg;
    acc_req_t  push;
    q_status_t q;
    logic      pop;

    assign cfg_ready = 1'b1;

    // configuration register file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.x_ofs    <= '0;
            cfg_reg.w_ofs    <= '0;
            cfg_reg.zp_out   <= '0;
            cfg_reg.q_mult   <= MULT_RESET;
            cfg_reg.q_shift  <= '0;
            cfg_reg.clamp_lo <= ACT_MIN_RESET;
            cfg_reg.clamp_hi <= ACT_MAX_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_addr)
                REG_X_OFS:    cfg_reg.x_ofs    <= cfg_data[8:0];
                REG_W_OFS:    cfg_reg.w_ofs    <= cfg_data[8:0];
                REG_ZP_OUT:   cfg_reg.zp_out   <= cfg_data[7:0];
                REG_Q_MULT:   cfg_reg.q_mult   <= cfg_data[30:0];
                REG_Q_SHIFT:  cfg_reg.q_shift  <= cfg_data[6:0];
                REG_CLAMP_LO: cfg_reg.clamp_lo <= cfg_data[7:0];
                REG_CLAMP_HI: cfg_reg.clamp_hi <= cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // mac front end
    icmr_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .tap_vld      (s_tvalid),
        .tap_value    (s_tdata[7:0]),
        .tap_padded   (s_tuser[0]),
        .weight_value (s_tdata[15:8]),
        .bias_value   (s_tdata[47:16]),
        .first_tap    (s_tuser[1]),
        .last_tap     (s_tlast),
        .tap_rdy      (s_tready),
        .q_full       (q.full),
        .push         (push)
    );

    // accumulator queue
    icmr_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (pop),
        .status  (q)
    );

    // requantizer
    icmr_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q        (q),
        .pop      (pop),
        .res_vld  (m_tvalid),
        .res_data (m_tdata),
        .res_rdy  (m_tready)
    );

endmodule

### sv/icmr_front.sv
module icmr_front (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  icmr_pkg::cfg_t           cfg,
    input  logic                     tap_vld,
    input  logic signed [7:0]        tap_value,
    input  logic                     tap_padded,
    input  logic signed [7:0]        weight_value,
    input  logic [31:0]              bias_value,
    input  logic                     first_tap,
    input  logic                     last_tap,
    output logic                     tap_rdy,
    input  logic                     q_full,
    output icmr_pkg::acc_req_t       push
);
    import icmr_pkg::*;

    logic [31:0]        acc_reg;
    logic [31:0]        acc_next;
    logic signed [9:0]  xa;
    logic signed [9:0]  wa;
    logic signed [19:0] prod;
    logic [31:0]        base;
    logic               take;

    // taps stall only while the result queue has no room
    assign tap_rdy = !q_full;
    assign take    = tap_vld && tap_rdy;

    // offset operands stay within ten bits, so the int16 wrap never bites
    assign xa   = 10'(tap_value) + 10'(cfg.x_ofs);
    assign wa   = 10'(weight_value) + 10'(cfg.w_ofs);
    assign prod = xa * wa;

    // accumulate, restarting from the bias on a first tap
    always_comb begin
        base     = first_tap ? bias_value : acc_reg;
        acc_next = tap_padded ? base : base + 32'(prod);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else if (take) begin
            acc_reg <= acc_next;
        end
    end

    // hand the finished sum to the queue on the last tap
    assign push.vld = take && last_tap;
    assign push.acc = acc_next;

endmodule

### sv/icmr_queue.sv
module icmr_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  icmr_pkg::acc_req_t  push,
    input  logic                pop,
    output icmr_pkg::q_status_t status
);
    import icmr_pkg::*;

    logic [31:0]  mem_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg;
    logic [QAW-1:0] rd_ptr_reg;
    logic [QAW:0]   count_reg;
    logic [QAW:0]   count_next;
    logic           do_push;
    logic           do_pop;

    assign do_push = push.vld && (count_reg != (QAW+1)'(QDEPTH));
    assign do_pop  = pop && (count_reg != '0);

    // occupancy
    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push.acc;
        end
    end

    assign status.vld  = (count_reg != '0);
    assign status.full = (count_reg == (QAW+1)'(QDEPTH));
    assign status.acc  = mem_reg[rd_ptr_reg];

endmodule

### sv/icmr_back.sv
module icmr_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  icmr_pkg::cfg_t      cfg,
    input  icmr_pkg::q_status_t q,
    output logic                pop,
    output logic                res_vld,
    output logic [7:0]          res_data,
    input  logic                res_rdy
);
    import icmr_pkg::*;

    bk_state_t          state_reg;
    bk_state_t          state_next;
    logic [31:0]        acc_reg;
    logic signed [63:0] prod_reg;
    logic signed [31:0] scaled_reg;
    logic signed [15:0] v16_reg;
    logic signed [15:0] v16_next;
    logic               out_vld_reg;
    logic               out_vld_next;
    logic [7:0]         out_data_reg;
    logic [7:0]         out_data_next;

    logic [6:0]         nshift;
    logic [4:0]         lk;
    logic [4:0]         rk;
    logic [31:0]        lsh;
    logic [33:0]        rnd;
    logic signed [33:0] rsum;
    logic signed [33:0] rsh;
    logic signed [63:0] psum;
    logic signed [15:0] vo;
    logic signed [15:0] vc;

    // saturate to int16
    function automatic logic signed [15:0] clip16(input logic signed [33:0] v);
        logic signed [15:0] r;
        if (v > 34'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -34'sd32768) begin
            r = -16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    // rounding of the q0.31 product
    assign psum = prod_reg + 64'sh4000_0000;

    // signed shift with round half up
    always_comb begin
        nshift = 7'd0 - cfg.q_shift;
        lk     = nshift[4:0];
        rk     = cfg.q_shift[4:0];
        lsh    = scaled_reg << lk;
        rnd    = (34'd1 << rk) >> 1;
        rsum   = 34'(scaled_reg) + $signed(rnd);
        rsh    = rsum >>> rk;
        if (cfg.q_shift[6]) begin
            v16_next = clip16(34'($signed(lsh)));
        end else if (cfg.q_shift[5]) begin
            v16_next = '0;
        end else begin
            v16_next = clip16(rsh);
        end
    end

    // zero point with 16-bit wrap, then clamp, max bound last
    always_comb begin
        vo = v16_reg + 16'(cfg.zp_out);
        vc = vo;
        if (vc < 16'(cfg.clamp_lo)) begin
            vc = 16'(cfg.clamp_lo);
        end
        if (vc > 16'(cfg.clamp_hi)) begin
            vc = 16'(cfg.clamp_hi);
        end
    end

    // sequencer and output register
    always_comb begin
        state_next    = state_reg;
        pop           = 1'b0;
        out_vld_next  = out_vld_reg && !res_rdy;
        out_data_next = out_data_reg;
        case (state_reg)
            BK_IDLE: begin
                if (q.vld) begin
                    pop        = 1'b1;
                    state_next = BK_MUL;
                end
            end
            BK_MUL: begin
                state_next = BK_SCALE;
            end
            BK_SCALE: begin
                state_next = BK_SHIFT;
            end
            BK_SHIFT: begin
                state_next = BK_OUT;
            end
            BK_OUT: begin
                if (!out_vld_reg || res_rdy) begin
                    out_vld_next  = 1'b1;
                    out_data_next = vc[7:0];
                    state_next    = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            out_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
        if (pop) begin
            acc_reg <= q.acc;
        end
        if (state_reg == BK_MUL) begin
            prod_reg <= $signed(acc_reg) * $signed({1'b0, cfg.q_mult});
        end
        if (state_reg == BK_SCALE) begin
            scaled_reg <= psum[62:31];
        end
        if (state_reg == BK_SHIFT) begin
            v16_reg <= v16_next;
        end
    end

    assign res_vld  = out_vld_reg;
    assign res_data = out_data_reg;

endmodule

### dv/int8_conv_mac_requantize_test.sv
`timescale 1ns / 100ps

module int8_conv_mac_requantize_test;
    import icmr_pkg::*;

    // one convolution tap as offered on the slave stream
    typedef struct {
        logic [7:0]  x;
        logic [7:0]  w;
        bit          pad;
        logic [31:0] bias;
        bit          first;
        bit          last;
    } tap_t;

    // directed step: either a register write or a tap with optional known result
    typedef struct {
        bit          is_cfg;
        cfg_index_t  idx;
        int          val;
        tap_t        tap;
        bit          typed;
        logic [7:0]  res;
    } step_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    cfg_index_t  cfg_addr = REG_X_OFS;
    logic [31:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;   // tap_value[7:0], weight_value[15:8], bias_value[47:16]
    logic [1:0]  s_tuser = '0;   // tap_padded[0], first_tap[1]
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;        // result[7:0]

    // known result travelling beside the tap request
    bit          row_typed = 1'b0;
    logic [7:0]  row_res = '0;

    // predictor state
    cfg_t        qcfg;
    logic [31:0] mac_acc;
    logic [7:0]  pending_results[$];
    int          mismatch_count = 0;
    int          taps_sent = 0;

    // idling control
    int          gap_pct = 0;
    int          stall_pct = 0;
    bit          hold_tog = 1'b0;
    bit          hold_seen = 1'b0;
    int          hold_left = 0;

    step_row_t   rows[$];

    int8_conv_mac_requantize uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic longint clip16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // fold one tap into the accumulator
    function automatic logic [31:0] mac_update(logic [31:0] acc, logic [7:0] x,
                                               logic [7:0] w, bit pad,
                                               logic [31:0] bias, bit first);
        logic [31:0]        a;
        logic signed [15:0] xa;
        logic signed [15:0] wa;
        logic signed [31:0] prod;
        a = first ? bias : acc;
        if (!pad) begin
            xa = $signed(x) + $signed(qcfg.x_ofs);
            wa = $signed(w) + $signed(qcfg.w_ofs);
            prod = xa * wa;
            a = a + prod;
        end
        return a;
    endfunction

    // q0.31 rounding multiply, rounding shift, zero point and clamp
    function automatic logic [7:0] requantize_acc(logic [31:0] acc);
        longint      av;
        longint      p;
        longint      scaled;
        longint      v;
        int          shamt;
        int          k;
        logic [31:0] sh;
        av = longint'($signed(acc));
        shamt = int'($signed(qcfg.q_shift));
        p = av * longint'(qcfg.q_mult) + (longint'(1) <<< 30);
        scaled = p >>> 31;
        if (shamt < 0) begin
            k = (-shamt) & 31;
            sh = scaled[31:0] << k;
            v = clip16(longint'($signed(sh)));
        end else if (shamt < 32) begin
            if (shamt == 0)
                v = scaled;
            else
                v = (scaled + (longint'(1) <<< (shamt - 1))) >>> shamt;
            v = clip16(v);
        end else begin
            v = 0;
        end
        v = v + longint'($signed(qcfg.zp_out));
        if (v > 32767) v = v - 65536;
        if (v < -32768) v = v + 65536;
        if (v < longint'($signed(qcfg.clamp_lo))) v = longint'($signed(qcfg.clamp_lo));
        if (v > longint'($signed(qcfg.clamp_hi))) v = longint'($signed(qcfg.clamp_hi));
        return v[7:0];
    endfunction

    // prediction on accepted requests, checking on delivered results
    always @(posedge aclk) begin
        logic [7:0] want;
        if (!aresetn) begin
            qcfg.x_ofs    <= '0;
            qcfg.w_ofs    <= '0;
            qcfg.zp_out   <= '0;
            qcfg.q_mult   <= MULT_RESET;
            qcfg.q_shift  <= '0;
            qcfg.clamp_lo <= ACT_MIN_RESET;
            qcfg.clamp_hi <= ACT_MAX_RESET;
            mac_acc = '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_addr)
                    REG_X_OFS:    qcfg.x_ofs    <= cfg_data[8:0];
                    REG_W_OFS:    qcfg.w_ofs    <= cfg_data[8:0];
                    REG_ZP_OUT:   qcfg.zp_out   <= cfg_data[7:0];
                    REG_Q_MULT:   qcfg.q_mult   <= cfg_data[30:0];
                    REG_Q_SHIFT:  qcfg.q_shift  <= cfg_data[6:0];
                    REG_CLAMP_LO: qcfg.clamp_lo <= cfg_data[7:0];
                    REG_CLAMP_HI: qcfg.clamp_hi <= cfg_data[7:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                mac_acc = mac_update(mac_acc, s_tdata[7:0], s_tdata[15:8], s_tuser[0],
                                     s_tdata[47:16], s_tuser[1]);
                if (s_tlast)
                    pending_results.push_back(row_typed ? row_res : requantize_acc(mac_acc));
            end
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result %0d with nothing pending",
                                 $signed(m_tdata));
                end else begin
                    want = pending_results.pop_front();
                    if (m_tdata !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("result mismatch: expected %0d, got %0d",
                                     $signed(want), $signed(m_tdata));
                    end
                end
            end
        end
    end

    // receiver: random stalls plus a long hold-off on request
    always @(posedge aclk) begin
        if (hold_tog != hold_seen) begin
            hold_seen <= hold_tog;
            hold_left <= 300;
            m_tready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic void add_tap(int x, int w, bit pad, logic [31:0] bias, bit first,
                                    bit last, bit typed, logic [7:0] res);
        step_row_t r;
        r.is_cfg    = 1'b0;
        r.idx       = REG_X_OFS;
        r.val       = 0;
        r.tap.x     = x[7:0];
        r.tap.w     = w[7:0];
        r.tap.pad   = pad;
        r.tap.bias  = bias;
        r.tap.first = first;
        r.tap.last  = last;
        r.typed     = typed;
        r.res       = res;
        rows.push_back(r);
    endfunction

    function automatic void add_cfg(cfg_index_t idx, int val);
        step_row_t r;
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.val    = val;
        r.typed  = 1'b0;
        r.res    = '0;
        rows.push_back(r);
    endfunction

    // mostly typical values, sometimes the range ends
    function automatic int pick(int lo, int hi, int typ_lo, int typ_hi);
        int r;
        r = $urandom_range(9);
        if (r == 0) return lo;
        if (r == 1) return hi;
        return int'($urandom_range(typ_hi - typ_lo)) + typ_lo;
    endfunction

    task automatic send_tap(tap_t t, bit typed, logic [7:0] res);
        s_tvalid  <= 1'b1;
        s_tdata   <= {t.bias, t.w, t.x};
        s_tuser   <= {t.first, t.pad};
        s_tlast   <= t.last;
        row_typed <= typed;
        row_res   <= res;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic cfg_write(cfg_index_t idx, int val);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // stop offering taps until every pending result is back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic rand_config();
        cfg_write(REG_X_OFS,    pick(-256, 255, -256, 255));
        cfg_write(REG_W_OFS,    pick(-256, 255, -16, 16));
        cfg_write(REG_ZP_OUT,   pick(-128, 127, -128, 127));
        cfg_write(REG_Q_MULT,   pick(0, 32'h7fff_ffff, 32'h2000_0000, 32'h7fff_ffff));
        cfg_write(REG_Q_SHIFT,  pick(-31, 63, -2, 16));
        cfg_write(REG_CLAMP_LO, pick(-128, 127, -128, -40));
        cfg_write(REG_CLAMP_HI, pick(-128, 127, 40, 127));
    endtask

    // one conv window with random content, or a broken one when noisy
    task automatic send_window(int len, bit noise);
        tap_t t;
        for (int j = 0; j < len; j++) begin
            t.x     = 8'($urandom);
            t.w     = 8'($urandom);
            t.pad   = ($urandom_range(99) < 20);
            t.bias  = ($urandom_range(19) == 0) ? $urandom : $urandom_range(200000) - 100000;
            t.first = (j == 0);
            t.last  = (j == len - 1);
            if (noise) begin
                t.first = ($urandom_range(1) != 0);
                t.last  = ($urandom_range(1) != 0);
            end
            while ($urandom_range(99) < gap_pct) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
            send_tap(t, 1'b0, 8'h00);
            taps_sent++;
        end
    endtask

    initial begin
        int ph;
        int mode;

        // directed steps, starting from reset settings
        add_tap(   0,    0, 0, 32'd0,         1, 1, 1, 8'h00);
        add_tap(   0,    0, 0, 32'd100,       1, 1, 1, 8'h32);
        add_tap( 127,  127, 0, 32'd0,         1, 1, 1, 8'h7f);
        add_tap(-128,  127, 0, 32'd0,         1, 1, 1, 8'h80);
        add_tap( 127,  127, 1, 32'd7,         1, 1, 1, 8'h04);
        add_tap(   0,    0, 1, 32'h7fff_ffff, 1, 1, 1, 8'h7f);
        add_tap(   0,    0, 1, 32'h8000_0000, 1, 1, 1, 8'h80);
        // multi-tap window with a padded tap inside
        add_tap(   3,    4, 0, 32'd10,        1, 0, 0, 8'h00);
        add_tap(  -5,    6, 0, 32'd99,        0, 0, 0, 8'h00);
        add_tap( 127,  127, 1, 32'd99,        0, 0, 0, 8'h00);
        add_tap(   2,    2, 0, 32'd99,        0, 1, 0, 8'h00);
        // no first tap: accumulator carries over from the last window
        add_tap(   1,    1, 0, 32'd55,        0, 1, 0, 8'h00);
        // padded first tap still loads the bias, padded last still emits
        add_tap(  50,   50, 1, 32'd5,         1, 0, 0, 8'h00);
        add_tap(  50,   50, 1, 32'd0,         0, 1, 0, 8'h00);
        // right shift of 32 or more gives zero
        add_cfg(REG_Q_SHIFT, 40);
        add_tap(   0,    0, 1, 32'd1000,      1, 1, 1, 8'h00);
        add_cfg(REG_Q_SHIFT, 63);
        add_tap(   0,    0, 1, -32'sd1000,    1, 1, 1, 8'h00);
        // left shift beyond 31 uses the low five bits only
        add_cfg(REG_Q_SHIFT, -33);
        add_tap(   0,    0, 1, 32'd100,       1, 1, 1, 8'h64);
        add_cfg(REG_Q_SHIFT, -31);
        add_tap(   0,    0, 1, 32'd2,         1, 1, 1, 8'h80);
        add_cfg(REG_Q_SHIFT, 3);
        add_tap(   0,    0, 1, 32'd100,       1, 1, 0, 8'h00);
        add_cfg(REG_Q_SHIFT, 0);
        // zero point overflow wraps in 16 bits
        add_cfg(REG_ZP_OUT, 127);
        add_tap(   0,    0, 1, 32'h7fff_ffff, 1, 1, 1, 8'h80);
        add_cfg(REG_ZP_OUT, -128);
        add_tap(   0,    0, 1, 32'h8000_0000, 1, 1, 1, 8'h7f);
        add_cfg(REG_ZP_OUT, 0);
        // crossed bounds: max wins
        add_cfg(REG_CLAMP_LO, 50);
        add_cfg(REG_CLAMP_HI, -50);
        add_tap(   0,    0, 1, 32'd0,         1, 1, 1, 8'hce);
        add_cfg(REG_CLAMP_LO, -128);
        add_cfg(REG_CLAMP_HI, 127);
        // offset extremes
        add_cfg(REG_X_OFS, -256);
        add_cfg(REG_W_OFS, 255);
        add_tap( 127, -128, 0, 32'd0,         1, 1, 0, 8'h00);
        add_tap(-128,  127, 0, 32'd0,         1, 1, 0, 8'h00);
        add_cfg(REG_X_OFS, 255);
        add_cfg(REG_W_OFS, -256);
        add_tap( 127, -128, 0, 32'd0,         1, 1, 0, 8'h00);
        // multiplier extremes
        add_cfg(REG_Q_MULT, 32'h7fff_ffff);
        add_tap(   0,    0, 1, 32'd1000,      1, 1, 0, 8'h00);
        add_cfg(REG_Q_MULT, 0);
        add_tap(   0,    0, 1, 32'd12345,     1, 1, 1, 8'h00);

        // reset
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i]) begin
            if (rows[i].is_cfg) begin
                drain();
                cfg_write(rows[i].idx, rows[i].val);
            end else begin
                send_tap(rows[i].tap, rows[i].typed, rows[i].res);
            end
        end

        // random windows over several settings and idling phases
        for (ph = 0; ph < 10; ph++) begin
            drain();
            mode = ph % 4;
            case (mode)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 53; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 53; end
                default: begin gap_pct = 28; stall_pct = 28; end
            endcase
            rand_config();
            // long receiver hold-off while single-tap windows keep coming
            if (ph == 0 || ph == 5) begin
                hold_tog <= ~hold_tog;
                repeat (30) send_window(1, 1'b0);
            end
            while (taps_sent < (ph + 1) * 175) begin
                send_window($urandom_range(9, 1), $urandom_range(99) < 15);
                if ($urandom_range(99) < 3)
                    drain();
            end
        end

        drain();
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("int8_conv_mac_requantize_test: clean");
        else
            $display("int8_conv_mac_requantize_test: errors");
        $finish;
    end

    // run limit
    initial begin
        #5000000;
        $display("int8_conv_mac_requantize_test: errors");
        $finish;
    end

endmodule
